FILE: src/sqltok_pkg.sv
`timescale 1ns / 1ps
package sqltok_pkg;

    localparam int POS_BITS_DEF    = 16;
    localparam int KEYWORD_MAX_DEF = 10;
    localparam int KW_COUNT        = 69;
    localparam int KW_BASE         = 22;

    typedef enum logic [3:0] {
        OP_TEXT = 4'd0,
        OP_END  = 4'd1
    } op_code_t;

    // token kinds
    localparam logic [6:0] K_END     = 7'd0;
    localparam logic [6:0] K_IDENT   = 7'd1;
    localparam logic [6:0] K_NUMBER  = 7'd2;
    localparam logic [6:0] K_STRING  = 7'd3;
    localparam logic [6:0] K_UNKNOWN = 7'd4;
    localparam logic [6:0] K_LPAREN  = 7'd5;
    localparam logic [6:0] K_RPAREN  = 7'd6;
    localparam logic [6:0] K_COMMA   = 7'd7;
    localparam logic [6:0] K_DOT     = 7'd8;
    localparam logic [6:0] K_SEMI    = 7'd9;
    localparam logic [6:0] K_STAR    = 7'd10;
    localparam logic [6:0] K_EQ      = 7'd11;
    localparam logic [6:0] K_NE      = 7'd12;
    localparam logic [6:0] K_LT      = 7'd13;
    localparam logic [6:0] K_LE      = 7'd14;
    localparam logic [6:0] K_GT      = 7'd15;
    localparam logic [6:0] K_GE      = 7'd16;
    localparam logic [6:0] K_PLUS    = 7'd17;
    localparam logic [6:0] K_MINUS   = 7'd18;
    localparam logic [6:0] K_DIVIDE  = 7'd19;
    localparam logic [6:0] K_MODULO  = 7'd20;
    localparam logic [6:0] K_CONCAT  = 7'd21;

    // scanner modes, one-hot
    typedef enum logic [14:0] {
        M_IDLE        = 15'h0001,
        M_IDENT       = 15'h0002,
        M_NUMBER      = 15'h0004,
        M_STRING      = 15'h0008,
        M_STR_ESC     = 15'h0010,
        M_LINE_CMT    = 15'h0020,
        M_BLOCK_CMT   = 15'h0040,
        M_BLOCK_STAR  = 15'h0080,
        M_OP_LT       = 15'h0100,
        M_OP_GT       = 15'h0200,
        M_OP_BANG     = 15'h0400,
        M_OP_BAR      = 15'h0800,
        M_OP_MINUS    = 15'h1000,
        M_OP_SLASH    = 15'h2000,
        M_DRAIN       = 15'h4000
    } lex_mode_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] ch;
    } in_word_t;

    typedef struct packed {
        logic [6:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] start_column;
        logic [15:0] text_length;
        logic [7:0]  first_char;
        logic        last_of_run;
    } out_word_t;

    // keyword text, left aligned, space padded; kw_len gives its length
    localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
        "SELECT    ", "FROM      ", "WHERE     ", "INSERT    ", "INTO      ",
        "VALUES    ", "UPDATE    ", "SET       ", "DELETE    ", "CREATE    ",
        "TABLE     ", "DROP      ", "ALTER     ", "ADD       ", "MODIFY    ",
        "PRIMARY   ", "KEY       ", "NOT       ", "NULL      ", "UNIQUE    ",
        "FOREIGN   ", "REFERENCES", "DEFAULT   ", "CHECK     ", "CONSTRAINT",
        "AND       ", "OR        ", "IN        ", "BETWEEN   ", "LIKE      ",
        "IS        ", "ORDER     ", "BY        ", "GROUP     ", "HAVING    ",
        "LIMIT     ", "OFFSET    ", "DISTINCT  ", "INNER     ", "LEFT      ",
        "RIGHT     ", "FULL      ", "OUTER     ", "JOIN      ", "ON        ",
        "USING     ", "UNION     ", "INTERSECT ", "EXCEPT    ", "CASE      ",
        "WHEN      ", "THEN      ", "ELSE      ", "END       ", "AS        ",
        "ASC       ", "DESC      ", "INT       ", "BIGINT    ", "FLOAT     ",
        "DOUBLE    ", "DECIMAL   ", "VARCHAR   ", "CHAR      ", "BOOLEAN   ",
        "DATE      ", "TIMESTAMP ", "TEXT      ", "BLOB      "
    };

    function automatic logic [3:0] kw_len(input logic [79:0] t);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 10; k++) begin
            if (t[79-8*k -: 8] != 8'h20) n = 4'(k + 1);
        end
        return n;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

endpackage

FILE: src/sqltok_kwmatch.sv
`timescale 1ns / 1ps
module sqltok_kwmatch
    import sqltok_pkg::*;
#(
    parameter int KEYWORD_MAX = KEYWORD_MAX_DEF,
    parameter int LEN_BITS    = POS_BITS_DEF
)
(
    input  logic [KEYWORD_MAX-1:0][7:0] word,
    input  logic [LEN_BITS-1:0]         word_len,
    input  logic                        too_long,
    output logic [6:0]                  kind
);

    // compare the buffered word against every keyword in parallel
    always_comb
    begin
        logic hit;
        logic [3:0] kl;
        kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            kl  = kw_len(KW_TEXT[i]);
            hit = !too_long && (word_len == LEN_BITS'(kl));
            for (int k = 0; k < 10; k++) begin
                if (k < int'(kl) && k < KEYWORD_MAX) begin
                    if (word[k] != KW_TEXT[i][79-8*k -: 8]) hit = 1'b0;
                end
            end
            if (hit) kind = 7'(KW_BASE + i);
        end
    end

endmodule

FILE: src/sqltok_outq.sv
`timescale 1ns / 1ps
module sqltok_outq
    import sqltok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [1:0] push_n,
    input  out_word_t  push_a,
    input  out_word_t  push_b,
    output logic       room,
    output logic       out_valid,
    output out_word_t  out_word,
    input  logic       out_stall
);

    // four-entry queue; takes up to two words a cycle
    out_word_t  mem_reg [4];
    logic [1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = cnt_reg != 3'd0 && !out_stall;
    assign out_valid = cnt_reg != 3'd0;
    assign out_word  = mem_reg[rd_reg];
    assign room      = (cnt_reg - 3'(pop)) <= 3'd2;

    always_comb
    begin
        logic [1:0] np;
        np       = push ? push_n : 2'd0;
        rd_next  = rd_reg + 2'(pop);
        wr_next  = wr_reg + np;
        cnt_next = cnt_reg + 3'(np) - 3'(pop);
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 2'd0;
            wr_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // store pushed words
    always_ff @(posedge clk)
    begin
        if (push && push_n != 2'd0) mem_reg[wr_reg] <= push_a;
        if (push && push_n == 2'd2) mem_reg[wr_reg + 2'd1] <= push_b;
    end

endmodule

FILE: src/sql_tokenizer.sv
`timescale 1ns / 1ps
// Result words: each is written into the output queue when its byte is taken and shown from there.
// Throughput: one byte per cycle while in_stall is low; the scanner state is registered per byte taken.
// Up to two words per byte enter a four-entry output queue drained one per cycle while out_stall is low.
// Input stalls only while the queue lacks room for two words.
// Reset (rst_n low, asynchronous): idle, line 1, column 1, queue empty.
module sql_tokenizer
    import sqltok_pkg::*;
#(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam logic [POS_BITS-1:0] PMAX = '1;
    localparam logic [POS_BITS-1:0] PONE = POS_BITS'(1);

    lex_mode_t mode_reg, mode_next;
    logic [POS_BITS-1:0] cline_reg, cline_next, ccol_reg, ccol_next;
    logic [POS_BITS-1:0] tline_reg, tline_next, tcol_reg, tcol_next;
    logic [POS_BITS-1:0] tlen_reg, tlen_next;
    logic [7:0] tfirst_reg, tfirst_next, quote_reg, quote_next;
    logic dot_reg, dot_next, long_reg, long_next;
    logic [KEYWORD_MAX-1:0][7:0] wbuf_reg, wbuf_next;

    logic room, take;
    logic [6:0] wkind;
    logic [1:0] n;
    out_word_t ra, rb;

    assign in_stall = !room;
    assign take     = in_valid && room;

    sqltok_kwmatch #(.KEYWORD_MAX(KEYWORD_MAX), .LEN_BITS(POS_BITS)) u_kw (
        .word(wbuf_reg), .word_len(tlen_reg), .too_long(long_reg), .kind(wkind)
    );

    function automatic logic [15:0] f16(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    // scan one byte
    always_comb
    begin
        logic [7:0] c;
        logic again, fl, ed;
        logic [6:0] k;
        logic [POS_BITS-1:0] fl_len;
        logic [7:0] fl_first, ec;
        mode_next = mode_reg; cline_next = cline_reg; ccol_next = ccol_reg;
        tline_next = tline_reg; tcol_next = tcol_reg; tlen_next = tlen_reg;
        tfirst_next = tfirst_reg; quote_next = quote_reg; dot_next = dot_reg;
        long_next = long_reg; wbuf_next = wbuf_reg;
        n = 2'd0; ra = '0; rb = '0;
        c = in_word.ch; again = 1'b0; fl = 1'b0; ed = 1'b0;
        k = K_IDENT; fl_len = tlen_reg; fl_first = tfirst_reg; ec = c;

        // what a flush of the held token gives
        case (mode_reg)
            M_IDENT:   k = wkind;
            M_NUMBER:  k = K_NUMBER;
            M_STRING:  k = K_STRING;
            M_STR_ESC:
            begin
                k = K_STRING;
                fl_first = (tlen_reg == '0) ? 8'd0 : tfirst_reg;
                fl_len = (tlen_reg == PMAX) ? PMAX : tlen_reg + 1'b1;
            end
            M_OP_LT:   begin k = K_LT;      fl_len = PONE; fl_first = "<"; end
            M_OP_GT:   begin k = K_GT;      fl_len = PONE; fl_first = ">"; end
            M_OP_BANG: begin k = K_UNKNOWN; fl_len = PONE; fl_first = "!"; end
            M_OP_BAR:  begin k = K_UNKNOWN; fl_len = PONE; fl_first = "|"; end
            M_OP_MINUS: begin k = K_MINUS;  fl_len = PONE; fl_first = "-"; end
            M_OP_SLASH: begin k = K_DIVIDE; fl_len = PONE; fl_first = "/"; end
            default:   k = K_IDENT;
        endcase
        fl = mode_reg inside {M_IDENT, M_NUMBER, M_STRING, M_STR_ESC, M_OP_LT,
                              M_OP_GT, M_OP_BANG, M_OP_BAR, M_OP_MINUS, M_OP_SLASH};
        ra = '{k, f16(tline_reg), f16(tcol_reg), f16(fl_len), fl_first, 1'b0};

        if (in_word.operation)
        begin
            if (mode_reg != M_DRAIN)
            begin
                rb = '{K_END, f16(cline_reg), f16(ccol_reg), 16'd0, 8'd0, 1'b1};
                if (fl) n = 2'd2;
                else begin ra = rb; n = 2'd1; end
            end
            mode_next = M_IDLE;
            cline_next = PONE; ccol_next = PONE;
        end
        else if (mode_reg == M_DRAIN)
        begin
            n = 2'd0;
        end
        else if (c == 8'd0 && mode_reg != M_STR_ESC)
        begin
            rb = '{K_END, f16(cline_reg), f16(ccol_reg), 16'd0, 8'd0, 1'b1};
            if (fl) n = 2'd2;
            else begin ra = rb; n = 2'd1; end
            mode_next = M_DRAIN;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                    if (is_alpha(c) || is_digit(c) || c == "_")
                    begin
                        if (tlen_reg < POS_BITS'(KEYWORD_MAX))
                            wbuf_next[tlen_reg[$clog2(KEYWORD_MAX)-1:0]] = to_upper(c);
                        else long_next = 1'b1;
                        tlen_next = (tlen_reg == PMAX) ? PMAX : tlen_reg + 1'b1;
                    end
                    else begin ed = 1'b1; again = 1'b1; end
                M_NUMBER:
                    if (is_digit(c) || (c == "." && !dot_reg))
                    begin
                        if (c == ".") dot_next = 1'b1;
                        tlen_next = (tlen_reg == PMAX) ? PMAX : tlen_reg + 1'b1;
                    end
                    else begin ed = 1'b1; again = 1'b1; end
                M_STRING:
                    if (c == quote_reg) ed = 1'b1;
                    else if (c == "\\") mode_next = M_STR_ESC;
                    else
                    begin
                        if (tlen_reg == '0) tfirst_next = c;
                        tlen_next = (tlen_reg == PMAX) ? PMAX : tlen_reg + 1'b1;
                    end
                M_STR_ESC:
                begin
                    ec = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : (c == "r") ? 8'd13 : c;
                    if (tlen_reg == '0) tfirst_next = ec;
                    tlen_next = (tlen_reg == PMAX) ? PMAX : tlen_reg + 1'b1;
                    mode_next = M_STRING;
                end
                M_LINE_CMT:   if (c == "\n") mode_next = M_IDLE;
                M_BLOCK_CMT:  if (c == "*") mode_next = M_BLOCK_STAR;
                M_BLOCK_STAR:
                    if (c == "/") mode_next = M_IDLE;
                    else if (c != "*") mode_next = M_BLOCK_CMT;
                M_OP_LT:
                    if (c == ">" || c == "=")
                    begin
                        ra.token_kind = (c == ">") ? K_NE : K_LE;
                        ra.text_length = 16'd2; n = 2'd1; mode_next = M_IDLE;
                    end
                    else begin ed = 1'b1; again = 1'b1; end
                M_OP_GT, M_OP_BANG:
                    if (c == "=")
                    begin
                        ra.token_kind = (mode_reg == M_OP_GT) ? K_GE : K_NE;
                        ra.text_length = 16'd2; n = 2'd1; mode_next = M_IDLE;
                    end
                    else begin ed = 1'b1; again = 1'b1; end
                M_OP_BAR:
                    if (c == "|")
                    begin
                        ra.token_kind = K_CONCAT;
                        ra.text_length = 16'd2; n = 2'd1; mode_next = M_IDLE;
                    end
                    else begin ed = 1'b1; again = 1'b1; end
                M_OP_MINUS:
                    if (c == "-") mode_next = M_LINE_CMT;
                    else begin ed = 1'b1; again = 1'b1; end
                M_OP_SLASH:
                    if (c == "*") mode_next = M_BLOCK_CMT;
                    else begin ed = 1'b1; again = 1'b1; end
                default: again = 1'b1;
            endcase
            if (ed)
            begin
                n = 2'd1;
                mode_next = M_IDLE;
            end
            // start a new token from this byte
            if (again)
            begin
                if (is_space(c))
                begin
                end
                else if (c == "'" || c == "\"")
                begin
                    mode_next = M_STRING; quote_next = c;
                    tline_next = cline_reg; tcol_next = ccol_reg;
                    tlen_next = '0; tfirst_next = 8'd0;
                end
                else if (is_digit(c) || is_alpha(c) || c == "_")
                begin
                    mode_next = is_digit(c) ? M_NUMBER : M_IDENT;
                    dot_next = 1'b0; long_next = 1'b0;
                    wbuf_next[0] = to_upper(c);
                    tline_next = cline_reg; tcol_next = ccol_reg;
                    tlen_next = PONE; tfirst_next = c;
                end
                else if (c inside {"<", ">", "!", "|", "-", "/"})
                begin
                    case (c)
                        "<":     mode_next = M_OP_LT;
                        ">":     mode_next = M_OP_GT;
                        "!":     mode_next = M_OP_BANG;
                        "|":     mode_next = M_OP_BAR;
                        "-":     mode_next = M_OP_MINUS;
                        default: mode_next = M_OP_SLASH;
                    endcase
                    tline_next = cline_reg; tcol_next = ccol_reg;
                    tlen_next = '0; tfirst_next = 8'd0;
                end
                else
                begin
                    case (c)
                        "(":     k = K_LPAREN;
                        ")":     k = K_RPAREN;
                        ",":     k = K_COMMA;
                        ".":     k = K_DOT;
                        ";":     k = K_SEMI;
                        "*":     k = K_STAR;
                        "=":     k = K_EQ;
                        "+":     k = K_PLUS;
                        "%":     k = K_MODULO;
                        default: k = K_UNKNOWN;
                    endcase
                    rb = '{k, f16(cline_reg), f16(ccol_reg), 16'd1, c, 1'b0};
                    if (n == 2'd0) begin ra = rb; n = 2'd1; end
                    else n = 2'd2;
                end
            end
            // advance position
            if (c == "\n")
            begin
                cline_next = (cline_reg == PMAX) ? PMAX : cline_reg + 1'b1;
                ccol_next = PONE;
            end
            else ccol_next = (ccol_reg == PMAX) ? PMAX : ccol_reg + 1'b1;
        end
        if (n == 2'd1) ra.last_of_run = 1'b1;
        if (n == 2'd2) rb.last_of_run = 1'b1;
    end

    // hold scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            cline_reg <= PONE; ccol_reg <= PONE; tline_reg <= PONE; tcol_reg <= PONE;
            tlen_reg <= '0; tfirst_reg <= '0; quote_reg <= '0;
            dot_reg <= 1'b0; long_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            cline_reg <= cline_next; ccol_reg <= ccol_next;
            tline_reg <= tline_next; tcol_reg <= tcol_next;
            tlen_reg <= tlen_next; tfirst_reg <= tfirst_next; quote_reg <= quote_next;
            dot_reg <= dot_next; long_reg <= long_next;
        end
    end

    // word buffer holds no reset
    always_ff @(posedge clk)
    begin
        if (take) wbuf_reg <= wbuf_next;
    end

    sqltok_outq u_q (
        .clk(clk), .rst_n(rst_n), .push(take), .push_n(n), .push_a(ra), .push_b(rb),
        .room(room), .out_valid(out_valid), .out_word(out_word), .out_stall(out_stall)
    );

endmodule

FILE: src/sqltok_check.sv
`timescale 1ns / 1ps
module sqltok_check
    import sqltok_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_word_t  in_word,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed under stall");

    // an empty queue never holds off the input
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty queue");

    // END always closes a run and carries no text
    a_endw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.token_kind == K_END |->
            out_word.last_of_run && out_word.text_length == 16'd0)
        else $error("bad END word");

    // lines and columns start from one
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.token_line != 16'd0 && out_word.start_column != 16'd0)
        else $error("zero position");

endmodule

bind sql_tokenizer sqltok_check u_check (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
);
